@@ hw/rtl/spims_pkg.sv @@
// Shared types and codes for the SPI master shift engine.
package spims_pkg;

  localparam int CFG_IDX_W = 2;

  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_SELECT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_SPI_MODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd1;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       select_level;
    logic       miso;
  } req_t;

  typedef struct packed {
    logic       sck;
    logic       mosi;
    logic       ss_level;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
  } rsp_t;

endpackage

@@ hw/rtl/spi_master_shift_engine.sv @@
// SPI master shift engine, modes 0 to 3, MSB first.
// A result is registered and shows in the cycle after its item is taken.
// Throughput: one item per cycle unless a stalled result holds the input;
// the single-pass update of shift state and result register allows that.
// Reset (rst, synchronous, active high): mode 0, half period 1, idle,
// SCK low, SS high, no result pending.
module spi_master_shift_engine
  import spims_pkg::*;
#(
  parameter int FRAME_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  req_t                 req_item,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output rsp_t                 rsp_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  localparam int BL_W = $clog2(FRAME_BITS + 1);

  logic [1:0]            spi_mode;
  logic [7:0]            half_period_ticks;
  logic [FRAME_BITS-1:0] tx_shift, tx_shift_next;
  logic [FRAME_BITS-1:0] rx_shift, rx_shift_next;
  logic [FRAME_BITS-1:0] rx_hold, rx_hold_next;
  logic [BL_W-1:0]       bits_left, bits_left_next;
  logic                  second_edge, second_edge_next;
  logic [7:0]            tick_divider, tick_divider_next;
  logic                  clock_level, clock_level_next;
  logic                  data_out_level, data_out_level_next;
  logic                  select_out, select_out_next;
  logic                  running, running_next;
  logic                  done;

  logic                  accept;
  logic                  mode_wr;
  logic                  cpha;
  logic [7:0]            hp;
  logic [7:0]            div_inc;
  logic [BL_W-1:0]       bl_dec;
  logic [FRAME_BITS-1:0] rx_sampled;
  logic [FRAME_BITS-1:0] tx_load;
  logic [FRAME_BITS+7:0] tx_ext;
  logic [FRAME_BITS+7:0] rx_ext;
  rsp_t                  rsp_next;

  assign cfg_ready = 1'b1;
  assign req_stall = rsp_valid & rsp_stall;
  assign accept    = req_valid & ~req_stall;
  // mode change only when idle; SCK moves to the new idle level
  assign mode_wr   = cfg_valid & (cfg_index == CFG_SPI_MODE) & ~running;

  assign cpha       = spi_mode[0];
  assign hp         = (half_period_ticks == 8'd0) ? 8'd1 : half_period_ticks;
  assign div_inc    = tick_divider + 8'd1;
  assign bl_dec     = (bits_left != '0) ? bits_left - BL_W'(1) : '0;
  assign rx_sampled = {rx_shift[FRAME_BITS-2:0], req_item.miso};
  assign tx_ext     = {{FRAME_BITS{1'b0}}, req_item.tx_byte};
  assign tx_load    = tx_ext[FRAME_BITS-1:0];

  always_comb begin
    tx_shift_next       = tx_shift;
    rx_shift_next       = rx_shift;
    rx_hold_next        = rx_hold;
    bits_left_next      = bits_left;
    second_edge_next    = second_edge;
    tick_divider_next   = tick_divider;
    clock_level_next    = clock_level;
    data_out_level_next = data_out_level;
    select_out_next     = select_out;
    running_next        = running;
    done                = 1'b0;
    case (req_item.kind)
      KIND_TICK: begin
        if (running) begin
          if (div_inc >= hp) begin
            tick_divider_next = 8'd0;
            clock_level_next  = ~clock_level;
            if (!second_edge) begin
              // leading edge: drive for CPHA=1, sample for CPHA=0
              if (cpha) begin
                data_out_level_next = tx_shift[FRAME_BITS-1];
                tx_shift_next       = {tx_shift[FRAME_BITS-2:0], 1'b0};
              end else begin
                rx_shift_next = rx_sampled;
              end
              second_edge_next = 1'b1;
            end else begin
              second_edge_next = 1'b0;
              bits_left_next   = bl_dec;
              if (cpha) begin
                rx_shift_next = rx_sampled;
              end
              if (bl_dec == '0) begin
                running_next = 1'b0;
                rx_hold_next = cpha ? rx_sampled : rx_shift;
                done         = 1'b1;
              end else if (!cpha) begin
                data_out_level_next = tx_shift[FRAME_BITS-1];
                tx_shift_next       = {tx_shift[FRAME_BITS-2:0], 1'b0};
              end
            end
          end else begin
            tick_divider_next = div_inc;
          end
        end
      end
      KIND_START: begin
        if (!running) begin
          rx_shift_next     = '0;
          bits_left_next    = BL_W'(FRAME_BITS);
          second_edge_next  = 1'b0;
          tick_divider_next = 8'd0;
          running_next      = 1'b1;
          clock_level_next  = spi_mode[1];
          if (!cpha) begin
            data_out_level_next = tx_load[FRAME_BITS-1];
            tx_shift_next       = {tx_load[FRAME_BITS-2:0], 1'b0};
          end else begin
            tx_shift_next = tx_load;
          end
        end
      end
      KIND_SELECT: begin
        if (!running) begin
          select_out_next = req_item.select_level;
        end
      end
      default: begin
      end
    endcase
  end

  assign rx_ext = {8'd0, rx_hold_next};

  always_comb begin
    rsp_next.sck      = clock_level_next;
    rsp_next.mosi     = data_out_level_next;
    rsp_next.ss_level = select_out_next;
    rsp_next.rx_byte  = rx_ext[7:0];
    rsp_next.done_res = done;
    rsp_next.busy_res = running_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spi_mode          <= 2'd0;
      half_period_ticks <= 8'd1;
      tx_shift          <= '0;
      rx_shift          <= '0;
      rx_hold           <= '0;
      bits_left         <= '0;
      second_edge       <= 1'b0;
      tick_divider      <= 8'd0;
      clock_level       <= 1'b0;
      data_out_level    <= 1'b0;
      select_out        <= 1'b1;
      running           <= 1'b0;
    end else begin
      if (accept) begin
        tx_shift       <= tx_shift_next;
        rx_shift       <= rx_shift_next;
        rx_hold        <= rx_hold_next;
        bits_left      <= bits_left_next;
        second_edge    <= second_edge_next;
        tick_divider   <= tick_divider_next;
        data_out_level <= data_out_level_next;
        select_out     <= select_out_next;
        running        <= running_next;
      end
      if (mode_wr) begin
        clock_level <= cfg_data[1];
      end else if (accept) begin
        clock_level <= clock_level_next;
      end
      if (mode_wr) begin
        spi_mode <= cfg_data[1:0];
      end else if (cfg_valid && cfg_index == CFG_HALF_PERIOD) begin
        half_period_ticks <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_item <= rsp_next;
    end
  end

endmodule

@@ hw/rtl/spims_checker.sv @@
// Port-level checks for the SPI master shift engine, bound into the engine module.
module spims_checker
  import spims_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input rsp_t rsp_item
);

  // every taken item yields a result in the next cycle
  a_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> rsp_valid)
    else $error("no result one cycle after a taken item");

  // a waiting result blocks the input
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |-> req_stall)
    else $error("input taken while a result is stalled");

  // a completing item reports the engine idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_item.done_res |-> !rsp_item.busy_res)
    else $error("done raised while still busy");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
    else $error("stalled result changed");

endmodule

bind spi_master_shift_engine spims_checker u_spims_checker (.*);

@@ tb/testbench.sv @@
// Self-checking testbench for the SPI master shift engine, with an item-level pin predictor.
module testbench;
  import spims_pkg::*;

  localparam int FRAME_BITS = 8;
  localparam int ITEMS_TARGET = 1950;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PCT = 21;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 req_valid;
  logic                 req_stall;
  req_t                 req_item;
  logic                 rsp_valid;
  logic                 rsp_stall;
  rsp_t                 rsp_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [7:0]           cfg_data;

  spi_master_shift_engine #(.FRAME_BITS(FRAME_BITS)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predicted pin state of the master
  logic [1:0]            m_mode;
  logic [7:0]            m_half;
  logic [FRAME_BITS-1:0] m_txsr;
  logic [FRAME_BITS-1:0] m_rxsr;
  logic [FRAME_BITS-1:0] m_rxlat;
  int                    m_bits;
  logic                  m_phase2;
  logic [7:0]            m_div;
  logic                  m_sck;
  logic                  m_mosi;
  logic                  m_ss;
  logic                  m_busy;

  rsp_t expected_pins[$];
  int   err_count;
  int   item_count;
  int   hold_left;
  int   quiet_cycles;
  bit   sender_quiet;
  bit   recv_quiet;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void model_reset();
    m_mode   = 2'd0;
    m_half   = 8'd1;
    m_txsr   = '0;
    m_rxsr   = '0;
    m_rxlat  = '0;
    m_bits   = 0;
    m_phase2 = 1'b0;
    m_div    = 8'd0;
    m_sck    = 1'b0;
    m_mosi   = 1'b0;
    m_ss     = 1'b1;
    m_busy   = 1'b0;
  endfunction

  function automatic void model_config(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    if (idx == CFG_SPI_MODE) begin
      // mode is locked during a transfer; when idle SCK jumps to the new CPOL
      if (!m_busy) begin
        m_mode = val[1:0];
        m_sck  = m_mode[1];
      end
    end else if (idx == CFG_HALF_PERIOD) begin
      m_half = val;
    end
  endfunction

  function automatic void drive_bit();
    m_mosi = m_txsr[FRAME_BITS-1];
    m_txsr = m_txsr << 1;
  endfunction

  function automatic void take_bit(input logic mi);
    m_rxsr = {m_rxsr[FRAME_BITS-2:0], mi};
  endfunction

  // One SCK edge; returns 1 when the frame completes.
  function automatic logic sck_edge(input logic mi);
    m_sck = ~m_sck;
    if (!m_phase2) begin
      if (m_mode[0]) drive_bit();
      else take_bit(mi);
      m_phase2 = 1'b1;
      return 1'b0;
    end
    if (m_mode[0]) take_bit(mi);
    m_phase2 = 1'b0;
    if (m_bits > 0) m_bits--;
    if (m_bits == 0) begin
      m_busy  = 1'b0;
      m_rxlat = m_rxsr;
      return 1'b1;
    end
    if (!m_mode[0]) drive_bit();
    return 1'b0;
  endfunction

  function automatic rsp_t spi_predict_step(input req_t it);
    rsp_t       r;
    logic [7:0] hp;
    logic       fin;
    hp  = (m_half == 8'd0) ? 8'd1 : m_half;
    fin = 1'b0;
    case (it.kind)
      KIND_TICK: begin
        if (m_busy) begin
          m_div = m_div + 8'd1;
          if (m_div >= hp) begin
            m_div = 8'd0;
            fin   = sck_edge(it.miso);
          end
        end
      end
      KIND_START: begin
        if (!m_busy) begin
          m_txsr   = FRAME_BITS'(it.tx_byte);
          m_rxsr   = '0;
          m_bits   = FRAME_BITS;
          m_phase2 = 1'b0;
          m_div    = 8'd0;
          m_busy   = 1'b1;
          m_sck    = m_mode[1];
          // CPHA 0 puts the first bit out before the leading edge
          if (!m_mode[0]) drive_bit();
        end
      end
      KIND_SELECT: begin
        if (!m_busy) m_ss = it.select_level;
      end
      default: ;
    endcase
    r.sck      = m_sck;
    r.mosi     = m_mosi;
    r.ss_level = m_ss;
    r.rx_byte  = 8'(m_rxlat);
    r.done_res = fin;
    r.busy_res = m_busy;
    return r;
  endfunction

  function automatic req_t make_req(input logic [1:0] kind, input logic [7:0] tx,
                                    input logic sel, input logic mi);
    req_t r;
    r.kind         = kind;
    r.tx_byte      = tx;
    r.select_level = sel;
    r.miso         = mi;
    return r;
  endfunction

  function automatic req_t rand_req(input logic [1:0] kind);
    return make_req(kind, 8'($urandom_range(255)), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    err_count++;
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want) report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // All tasks below start and return at a falling edge.
  task automatic send_req(input req_t it);
    while (!sender_quiet && $urandom_range(99) < IDLE_PCT) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_item  = it;
    req_valid = 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_pins.push_back(spi_predict_step(it));
    item_count++;
    @(negedge clk);
    req_valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (expected_pins.size() != 0) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    wait_drained();
    cfg_index = idx;
    cfg_data  = val;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_config(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Maybe select, start, tick until the frame is done, maybe deselect; with stray commands.
  task automatic run_frame(input bit retune);
    int n;
    n = 0;
    if ($urandom_range(1)) send_req(make_req(KIND_SELECT, 8'($urandom_range(255)), 1'b0,
                                             1'($urandom_range(1))));
    send_req(rand_req(KIND_START));
    while (m_busy) begin
      if ($urandom_range(99) < 6) send_req(rand_req(2'($urandom_range(1, 3))));
      else send_req(rand_req(KIND_TICK));
      n++;
      if (retune && n == 5) begin
        cfg_write(CFG_SPI_MODE, 8'($urandom_range(255)));
        cfg_write(CFG_HALF_PERIOD, 8'($urandom_range(1, 3)));
      end
    end
    if ($urandom_range(1)) send_req(make_req(KIND_SELECT, 8'($urandom_range(255)), 1'b1,
                                             1'($urandom_range(1))));
  endtask

  task automatic test_reset_state();
    send_req(make_req(2'd3, 8'hFF, 1'b1, 1'b1));
    send_req(make_req(KIND_TICK, 8'h00, 1'b0, 1'b0));
    send_req(make_req(KIND_TICK, 8'hFF, 1'b1, 1'b1));
  endtask

  task automatic test_directed_frame();
    send_req(make_req(KIND_SELECT, 8'h00, 1'b0, 1'b0));
    send_req(make_req(KIND_SELECT, 8'hFF, 1'b1, 1'b1));
    send_req(make_req(KIND_SELECT, 8'h00, 1'b0, 1'b0));
    send_req(make_req(KIND_START, 8'hFF, 1'b0, 1'b1));
    for (int i = 0; i < 2 * FRAME_BITS; i++) begin
      // stray start and deselect must be dropped mid-frame
      if (i == 3) send_req(make_req(KIND_START, 8'h00, 1'b0, 1'b0));
      if (i == 6) send_req(make_req(KIND_SELECT, 8'h00, 1'b1, 1'b0));
      send_req(make_req(KIND_TICK, 8'h00, 1'b0, 1'b1));
    end
  endtask

  task automatic test_config_edges();
    cfg_write(CFG_SPI_MODE, 8'h03);
    cfg_write(CFG_HALF_PERIOD, 8'h00);
    send_req(make_req(KIND_START, 8'h00, 1'b0, 1'b0));
    repeat (3) send_req(make_req(KIND_TICK, 8'hFF, 1'b1, 1'b0));
    // mode change is dropped while busy, half period applies at once
    cfg_write(CFG_SPI_MODE, 8'h00);
    cfg_write(CFG_HALF_PERIOD, 8'hFF);
    repeat (20) send_req(rand_req(KIND_TICK));
    cfg_write(CFG_HALF_PERIOD, 8'h01);
    while (m_busy) send_req(rand_req(KIND_TICK));
    send_req(make_req(KIND_SELECT, 8'h00, 1'b1, 1'b0));
    cfg_write(CFG_UNUSED, 8'hFF);
    cfg_write(CFG_SPI_MODE, 8'h02);
    send_req(make_req(2'd3, 8'h00, 1'b0, 1'b0));
    cfg_write(CFG_SPI_MODE, 8'hFD);
    send_req(make_req(2'd3, 8'h00, 1'b0, 1'b0));
  endtask

  task automatic test_full_speed();
    sender_quiet = 1'b1;
    recv_quiet   = 1'b1;
    cfg_write(CFG_HALF_PERIOD, 8'h01);
    repeat (6) run_frame(1'b0);
    sender_quiet = 1'b0;
    recv_quiet   = 1'b0;
  endtask

  task automatic test_backpressure();
    sender_quiet = 1'b1;
    hold_left    = HOLD_CYCLES;
    repeat (3) run_frame(1'b0);
    sender_quiet = 1'b0;
  endtask

  task automatic test_random_frames();
    logic [7:0] hp;
    while (item_count < ITEMS_TARGET) begin
      cfg_write(CFG_SPI_MODE, 8'($urandom_range(255)));
      case ($urandom_range(9))
        0:       hp = 8'd0;
        1:       hp = 8'($urandom_range(4, 12));
        default: hp = 8'($urandom_range(1, 3));
      endcase
      cfg_write(CFG_HALF_PERIOD, hp);
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(99) < 80) begin
          run_frame($urandom_range(99) < 10);
        end else begin
          repeat ($urandom_range(3, 10)) send_req(rand_req(2'($urandom_range(3))));
        end
      end
    end
  endtask

  // Receiver: random stalls, plus a long hold-off when requested
  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        rsp_stall = 1'b1;
        hold_left--;
      end else begin
        rsp_stall = !recv_quiet && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin : result_check
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_pins.size() == 0) begin
        report_mismatch("result with no expectation");
      end else begin
        want = expected_pins.pop_front();
        check_field("sck", rsp_item.sck, want.sck);
        check_field("mosi", rsp_item.mosi, want.mosi);
        check_field("ss_level", rsp_item.ss_level, want.ss_level);
        check_field("rx_byte", rsp_item.rx_byte, want.rx_byte);
        check_field("done_res", rsp_item.done_res, want.done_res);
        check_field("busy_res", rsp_item.busy_res, want.busy_res);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst          = 1'b1;
    req_valid    = 1'b0;
    req_item     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = 8'd0;
    err_count    = 0;
    item_count   = 0;
    hold_left    = 0;
    quiet_cycles = 0;
    sender_quiet = 1'b0;
    recv_quiet   = 1'b0;
    model_reset();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_directed_frame();
    test_config_edges();
    test_full_speed();
    test_backpressure();
    test_random_frames();

    wait_drained();
    repeat (4) @(posedge clk);
    if (expected_pins.size() != 0) report_mismatch("expected results left over");
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
